### design/fgs_pkg.sv
// ----------------------------------------------------------------------------
// fgs_pkg
// Types, grade tables and rule tables shared by the fuzzy gain scheduler.
// ----------------------------------------------------------------------------
package fgs_pkg;

  localparam int unsigned NSET    = 7;
  localparam int unsigned NIDX    = 13;
  localparam int unsigned NLANE   = 3;
  localparam int unsigned INT_BITS = 5;
  localparam int unsigned DEN_W   = 10;
  localparam int unsigned NUM_W   = DEN_W + INT_BITS;
  localparam int unsigned P_W     = 12;
  localparam int unsigned D_W     = 13;
  localparam int unsigned V_W     = 5;

  localparam int unsigned LANE_P = 0;
  localparam int unsigned LANE_D = 1;
  localparam int unsigned LANE_V = 2;

  typedef logic [6:0] grade_t;
  typedef logic [4:0] rule_t;

  localparam grade_t GRADE_ONE  = 7'd126;
  localparam grade_t GRADE_HALF = 7'd63;

  typedef struct packed {
    logic signed [15:0] error_in;
    logic signed [15:0] error_change;
  } in_word_t;

  typedef struct packed {
    logic [P_W-1:0] p_gain_q8;
    logic [D_W-1:0] d_gain_q8;
    logic [V_W-1:0] speed_value;
  } out_word_t;

  // scaled inputs, offset by six so that -6..6 maps to 0..12
  typedef struct packed {
    logic [3:0] e_idx;
    logic [3:0] ecg_idx;
    logic [3:0] ecv_idx;
  } idx_word_t;

  // gain error sets have uneven inner breakpoints
  localparam grade_t GAIN_E_GRADE [NIDX][NSET] = '{
    '{7'd126, 7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0  },
    '{7'd70,  7'd56,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0  },
    '{7'd14,  7'd112, 7'd0,   7'd0,   7'd0,   7'd0,   7'd0  },
    '{7'd0,   7'd72,  7'd54,  7'd0,   7'd0,   7'd0,   7'd0  },
    '{7'd0,   7'd0,   7'd126, 7'd0,   7'd0,   7'd0,   7'd0  },
    '{7'd0,   7'd0,   7'd63,  7'd63,  7'd0,   7'd0,   7'd0  },
    '{7'd0,   7'd0,   7'd0,   7'd126, 7'd0,   7'd0,   7'd0  },
    '{7'd0,   7'd0,   7'd0,   7'd63,  7'd63,  7'd0,   7'd0  },
    '{7'd0,   7'd0,   7'd0,   7'd0,   7'd126, 7'd0,   7'd0  },
    '{7'd0,   7'd0,   7'd0,   7'd0,   7'd54,  7'd72,  7'd0  },
    '{7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd112, 7'd14 },
    '{7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd56,  7'd70 },
    '{7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd126}
  };

  localparam rule_t P_RULE [NSET][NSET] = '{
    '{5'd13, 5'd13, 5'd13, 5'd12, 5'd12, 5'd11, 5'd11},
    '{5'd13, 5'd13, 5'd12, 5'd12, 5'd11, 5'd11, 5'd11},
    '{5'd13, 5'd12, 5'd12, 5'd11, 5'd11, 5'd10, 5'd10},
    '{5'd13, 5'd12, 5'd11, 5'd10, 5'd11, 5'd12, 5'd13},
    '{5'd10, 5'd10, 5'd11, 5'd11, 5'd12, 5'd12, 5'd13},
    '{5'd11, 5'd11, 5'd11, 5'd12, 5'd12, 5'd13, 5'd13},
    '{5'd11, 5'd11, 5'd12, 5'd12, 5'd13, 5'd13, 5'd13}
  };

  localparam rule_t D_RULE [NSET][NSET] = '{
    '{5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd27, 5'd26},
    '{5'd27, 5'd31, 5'd31, 5'd27, 5'd27, 5'd27, 5'd27},
    '{5'd27, 5'd31, 5'd27, 5'd27, 5'd27, 5'd27, 5'd26},
    '{5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd27, 5'd26},
    '{5'd26, 5'd27, 5'd27, 5'd27, 5'd27, 5'd31, 5'd27},
    '{5'd27, 5'd27, 5'd27, 5'd27, 5'd31, 5'd31, 5'd27},
    '{5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd27, 5'd26}
  };

  localparam rule_t V_RULE [NSET][NSET] = '{
    '{5'd0,  5'd0,  5'd0,  5'd0,  5'd5,  5'd9,  5'd9 },
    '{5'd0,  5'd0,  5'd0,  5'd5,  5'd9,  5'd9,  5'd18},
    '{5'd0,  5'd5,  5'd5,  5'd9,  5'd9,  5'd18, 5'd18},
    '{5'd0,  5'd5,  5'd9,  5'd18, 5'd9,  5'd5,  5'd0 },
    '{5'd18, 5'd18, 5'd9,  5'd9,  5'd5,  5'd5,  5'd0 },
    '{5'd18, 5'd9,  5'd9,  5'd5,  5'd0,  5'd0,  5'd0 },
    '{5'd9,  5'd9,  5'd5,  5'd0,  5'd0,  5'd0,  5'd0 }
  };

  // even spacing of two: set k peaks at index 2k, half grade one step away
  function automatic grade_t even_grade(logic [3:0] idx, logic [2:0] set);
    logic [3:0] ctr;
    logic [3:0] span;
    ctr  = {set, 1'b0};
    span = (idx >= ctr) ? idx - ctr : ctr - idx;
    if (span == 4'd0) begin
      return GRADE_ONE;
    end else if (span == 4'd1) begin
      return GRADE_HALF;
    end else begin
      return '0;
    end
  endfunction

endpackage

### design/fgs_front.sv
// ----------------------------------------------------------------------------
// fgs_front
// Input stage: clamps and scales error and error change to set indexes.
// ----------------------------------------------------------------------------
module fgs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fgs_pkg::in_word_t   in_data_i,
  output logic                full_o,
  output logic                valid_o,
  output fgs_pkg::idx_word_t  data_o,
  input  logic                ready_i
);

  localparam logic [6:0]  E_LIM     = 7'd80;
  localparam logic [6:0]  ECG_LIM   = 7'd15;
  localparam logic [6:0]  ECV_LIM   = 7'd12;
  localparam logic [15:0] RECIP_40  = 16'd205;
  localparam logic [12:0] RECIP_5   = 13'd205;
  localparam logic [3:0]  IDX_ZERO  = 4'd6;

  function automatic logic [6:0] mag_clamp(logic signed [15:0] x, logic [6:0] lim);
    logic [15:0] m;
    m = x[15] ? 16'(-x) : 16'(x);
    return (m > {9'd0, lim}) ? lim : m[6:0];
  endfunction

  function automatic logic [3:0] to_idx(logic neg, logic [2:0] q);
    return neg ? IDX_ZERO - {1'b0, q} : IDX_ZERO + {1'b0, q};
  endfunction

  logic               vld_q;
  fgs_pkg::idx_word_t idx_q, idx_d;
  logic [6:0]         e_mag, ecg_mag, ecv_mag;
  logic [7:0]         e_m3;
  logic [15:0]        e_prod;
  logic [4:0]         ecg_m2;
  logic [12:0]        ecg_prod;
  logic               take;

  // 3a/40 and 2b/5 on magnitudes by reciprocal multiply; exact over the clamp range
  always_comb begin
    e_mag    = mag_clamp(in_data_i.error_in, E_LIM);
    ecg_mag  = mag_clamp(in_data_i.error_change, ECG_LIM);
    ecv_mag  = mag_clamp(in_data_i.error_change, ECV_LIM);
    e_m3     = {1'b0, e_mag} + {e_mag, 1'b0};
    e_prod   = 16'(e_m3) * RECIP_40;
    ecg_m2   = {ecg_mag[3:0], 1'b0};
    ecg_prod = 13'(ecg_m2) * RECIP_5;
    idx_d.e_idx   = to_idx(in_data_i.error_in[15], e_prod[15:13]);
    idx_d.ecg_idx = to_idx(in_data_i.error_change[15], ecg_prod[12:10]);
    idx_d.ecv_idx = to_idx(in_data_i.error_change[15], ecv_mag[3:1]);
  end

  assign full_o  = vld_q && !ready_i;
  assign take    = push_i && !full_o;
  assign valid_o = vld_q;
  assign data_o  = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!full_o) begin
      vld_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      idx_q <= idx_d;
    end
  end

endmodule

### design/fgs_fifo.sv
// ----------------------------------------------------------------------------
// fgs_fifo
// Two-entry queue of scaled words between front and back.
// ----------------------------------------------------------------------------
module fgs_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  fgs_pkg::idx_word_t  wr_data_i,
  output logic                full_o,
  input  logic                rd_i,
  output fgs_pkg::idx_word_t  rd_data_o,
  output logic                empty_o
);

  // power of two, so pointers wrap on their own
  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  fgs_pkg::idx_word_t mem_q [DEPTH];
  logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               wr_ok, rd_ok;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign wr_ok     = wr_i && !full_o;
  assign rd_ok     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];
  assign cnt_d     = cnt_q + CW'(wr_ok) - CW'(rd_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_ok) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[PW-1:0] == PW'(wr_ptr_q - rd_ptr_q))
    else $error("fifo count out of step with pointers");
`endif

endmodule

### design/fgs_div.sv
// ----------------------------------------------------------------------------
// fgs_div
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fgs_div #(
  parameter int unsigned FRAC_BITS = 8,
  localparam int unsigned QW = FRAC_BITS + fgs_pkg::INT_BITS
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   en_i,
  input  logic                                                   vld_i,
  input  logic [fgs_pkg::NLANE-1:0][fgs_pkg::NUM_W-1:0]          num_i,
  input  logic [fgs_pkg::NLANE-1:0][fgs_pkg::DEN_W-1:0]          den_i,
  output logic                                                   vld_o,
  output logic [fgs_pkg::NLANE-1:0][QW-1:0]                      quo_o
);

  localparam int unsigned NL = fgs_pkg::NLANE;
  localparam int unsigned DW = fgs_pkg::DEN_W;
  localparam int unsigned IB = fgs_pkg::INT_BITS;

  // sh holds dividend bits still to come on top, quotient bits shifted in below
  logic [NL-1:0][DW-1:0] rem_q [QW];
  logic [NL-1:0][QW-1:0] sh_q  [QW];
  logic [NL-1:0][DW-1:0] den_q [QW];
  logic                  vld_q [QW];

  logic [NL-1:0][DW-1:0] rem_in [QW];
  logic [NL-1:0][QW-1:0] sh_in  [QW];
  logic [NL-1:0][DW-1:0] den_in [QW];
  logic                  vld_in [QW];
  logic [NL-1:0][DW-1:0] rem_d  [QW];
  logic [NL-1:0][QW-1:0] sh_d   [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < NL; l++) begin
          rem_in[s][l] = num_i[l][fgs_pkg::NUM_W-1:IB];
          sh_in[s][l]  = {num_i[l][IB-1:0], {FRAC_BITS{1'b0}}};
        end
      end
      assign den_in[s] = den_i;
      assign vld_in[s] = vld_i;
    end else begin : g_next
      assign rem_in[s] = rem_q[s-1];
      assign sh_in[s]  = sh_q[s-1];
      assign den_in[s] = den_q[s-1];
      assign vld_in[s] = vld_q[s-1];
    end

    always_comb begin
      logic [DW:0] t;
      logic        ge;
      for (int l = 0; l < NL; l++) begin
        t  = {rem_in[s][l], sh_in[s][l][QW-1]};
        ge = (t >= {1'b0, den_in[s][l]});
        rem_d[s][l] = ge ? DW'(t - {1'b0, den_in[s][l]}) : t[DW-1:0];
        sh_d[s][l]  = {sh_in[s][l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d[s];
        sh_q[s]  <= sh_d[s];
        den_q[s] <= den_in[s];
      end
    end
  end

  assign vld_o = vld_q[QW-1];
  assign quo_o = sh_q[QW-1];

endmodule

### design/fgs_back.sv
// ----------------------------------------------------------------------------
// fgs_back
// Inference pipeline: rule strengths, weighted sums, division, result word.
// ----------------------------------------------------------------------------
module fgs_back #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                src_valid_i,
  input  fgs_pkg::idx_word_t  src_data_i,
  output logic                src_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output fgs_pkg::out_word_t  out_data_o
);

  localparam int unsigned QW    = FRAC_BITS + fgs_pkg::INT_BITS;
  localparam int unsigned XW    = QW + fgs_pkg::D_W;
  localparam int unsigned NSET  = fgs_pkg::NSET;
  localparam int unsigned NL    = fgs_pkg::NLANE;
  localparam int unsigned NUM_W = fgs_pkg::NUM_W;
  localparam int unsigned DEN_W = fgs_pkg::DEN_W;

  typedef struct packed {
    logic [2:0]      col;
    fgs_pkg::grade_t best;
  } pick_t;

  // row maximum of min(g, gc[j]); first column wins a tie
  function automatic pick_t row_pick(fgs_pkg::grade_t g,
                                     fgs_pkg::grade_t [NSET-1:0] gc);
    pick_t           r;
    fgs_pkg::grade_t s;
    r.best = '0;
    r.col  = '0;
    for (int j = 0; j < NSET; j++) begin
      s = (g < gc[j]) ? g : gc[j];
      if (s > r.best) begin
        r.best = s;
        r.col  = 3'(j);
      end
    end
    return r;
  endfunction

  logic                          en;
  fgs_pkg::grade_t [NSET-1:0]    ge_g, gc_g, ge_v, gc_v;
  pick_t [NSET-1:0]              pick_g, pick_v;

  logic                          a_vld_q;
  pick_t [NSET-1:0]              a_g_q, a_v_q;

  logic [NL-1:0][NUM_W-1:0]      b_num_d, b_num_q;
  logic [NL-1:0][DEN_W-1:0]      b_den_d, b_den_q;
  logic                          b_vld_q;

  logic                          div_vld;
  logic [NL-1:0][QW-1:0]         quo;
  logic [XW-1:0]                 p_ext, d_ext;

  logic                          out_vld_q;
  fgs_pkg::out_word_t            out_q, out_d;

  assign en        = !out_vld_q || pop_i;
  assign src_pop_o = en && src_valid_i;

  always_comb begin
    for (int k = 0; k < NSET; k++) begin
      ge_g[k] = fgs_pkg::GAIN_E_GRADE[src_data_i.e_idx][k];
      gc_g[k] = fgs_pkg::even_grade(src_data_i.ecg_idx, 3'(k));
      ge_v[k] = fgs_pkg::even_grade(src_data_i.e_idx, 3'(k));
      gc_v[k] = fgs_pkg::even_grade(src_data_i.ecv_idx, 3'(k));
    end
    for (int i = 0; i < NSET; i++) begin
      pick_g[i] = row_pick(ge_g[i], gc_g);
      pick_v[i] = row_pick(ge_v[i], gc_v);
    end
  end

  always_comb begin
    b_num_d = '0;
    b_den_d = '0;
    for (int i = 0; i < NSET; i++) begin
      b_num_d[fgs_pkg::LANE_P] = b_num_d[fgs_pkg::LANE_P]
        + NUM_W'(a_g_q[i].best) * NUM_W'(fgs_pkg::P_RULE[i][a_g_q[i].col]);
      b_num_d[fgs_pkg::LANE_D] = b_num_d[fgs_pkg::LANE_D]
        + NUM_W'(a_g_q[i].best) * NUM_W'(fgs_pkg::D_RULE[i][a_g_q[i].col]);
      b_num_d[fgs_pkg::LANE_V] = b_num_d[fgs_pkg::LANE_V]
        + NUM_W'(a_v_q[i].best) * NUM_W'(fgs_pkg::V_RULE[i][a_v_q[i].col]);
      b_den_d[fgs_pkg::LANE_P] = b_den_d[fgs_pkg::LANE_P] + DEN_W'(a_g_q[i].best);
      b_den_d[fgs_pkg::LANE_V] = b_den_d[fgs_pkg::LANE_V] + DEN_W'(a_v_q[i].best);
    end
    b_den_d[fgs_pkg::LANE_D] = b_den_d[fgs_pkg::LANE_P];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q   <= src_valid_i;
      b_vld_q   <= a_vld_q;
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_g_q   <= pick_g;
      a_v_q   <= pick_v;
      b_num_q <= b_num_d;
      b_den_q <= b_den_d;
      out_q   <= out_d;
    end
  end

  fgs_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (b_vld_q),
    .num_i  (b_num_q),
    .den_i  (b_den_q),
    .vld_o  (div_vld),
    .quo_o  (quo)
  );

  // speed is the integer part of its own lane's scaled quotient
  always_comb begin
    p_ext = XW'(quo[fgs_pkg::LANE_P]);
    d_ext = XW'(quo[fgs_pkg::LANE_D]);
    out_d.p_gain_q8   = p_ext[fgs_pkg::P_W-1:0];
    out_d.d_gain_q8   = d_ext[fgs_pkg::D_W-1:0];
    out_d.speed_value = quo[fgs_pkg::LANE_V][FRAC_BITS +: fgs_pkg::V_W];
  end

  assign empty_o    = !out_vld_q;
  assign out_data_o = out_q;

`ifndef ASSERT_OFF
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q |-> (b_den_q[fgs_pkg::LANE_P] != '0) && (b_den_q[fgs_pkg::LANE_V] != '0))
    else $error("zero total rule weight");
`endif

endmodule

### design/fuzzy_gain_scheduler_unit.sv
// Path: front reg, queue, a and b regs, divider, out reg. Throughput: one word
// per cycle; the divider has FRAC_BITS + 5 stages, one quotient bit each, and
// the whole back pipeline advances while pop is held or out holds no word.
// Reset: asynchronous, clears valid flags and queue pointers; no tables to clear.
// ----------------------------------------------------------------------------
// fuzzy_gain_scheduler_unit
// Fuzzy P/D gain and speed scheduler over three 7x7 rule tables.
// ----------------------------------------------------------------------------
module fuzzy_gain_scheduler_unit #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  fgs_pkg::in_word_t   in_data_i,
  output logic                empty,
  input  logic                pop,
  output fgs_pkg::out_word_t  out_data_o
);

  logic               fr_vld;
  fgs_pkg::idx_word_t fr_data;
  logic               q_full, q_empty, q_rd;
  fgs_pkg::idx_word_t q_data;

  fgs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_data_i (in_data_i),
    .full_o    (full),
    .valid_o   (fr_vld),
    .data_o    (fr_data),
    .ready_i   (!q_full)
  );

  fgs_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fr_vld),
    .wr_data_i (fr_data),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_data),
    .empty_o   (q_empty)
  );

  fgs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (!q_empty),
    .src_data_i  (q_data),
    .src_pop_o   (q_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_data_o.speed_value <= 5'd18)
    else $error("speed word above table maximum");
`endif

endmodule
